// ===== src/ntc_pkg.sv =====
// Types and constants shared by the NTC code-to-temperature unit.
`default_nettype none
package ntc_pkg;

    typedef struct packed {
        logic [15:0] adc_code;
        logic [2:0]  module_index;
        logic [3:0]  sensor_index;
    } ntc_in_t;

    typedef struct packed {
        logic signed [12:0] temperature;
        logic [6:0]         slot_index;
    } ntc_out_t;

    typedef struct packed {
        logic       fault;
        logic [6:0] slot;
    } ntc_tag_t;

    typedef struct packed {
        ntc_tag_t    tag;
        logic [14:0] code;
    } ntc_job_t;

    typedef struct packed {
        logic     valid;
        ntc_job_t job;
    } ntc_push_t;

    localparam int QDEPTH = 2;
    localparam int LOG_LAT = 33;
    localparam int TDIV_STEPS = 5;
    localparam int QDIV_STEPS = 26;

    localparam logic [15:0] FULL_SCALE = 16'd30000;
    localparam logic [12:0] BETA = 13'd3435;
    localparam logic [28:0] RECIP_BETA = 29'd320090722;
    localparam logic [27:0] LN2_Q28 = 28'd186065279;
    localparam logic [63:0] T0_FULL = (64'd20 << 48) / 64'd5963;
    localparam logic [41:0] T0_INV_Q48 = T0_FULL[41:0];
    localparam logic [41:0] QDIV_INIT = 42'd20 << 30;
    localparam logic signed [26:0] KELVIN_OFS_Q8 = 27'sd1398528;
    localparam logic signed [26:0] MIN_TEMP_SCALED = -27'sd256000;
    localparam logic [15:0] RECIP5 = 16'd52429;
    localparam logic signed [12:0] FAULT_TEMP = 13'sd100;

endpackage
`default_nettype wire

// ===== src/ntc_front.sv =====
// Front end: accepts an item, flags invalid codes and forms the slot index.
`default_nettype none
module ntc_front
    import ntc_pkg::*;
#(
    parameter int THERMS_PER_MODULE = 16
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire ntc_in_t   sample,
    input  wire logic      queue_full,
    output logic           busy,
    output ntc_push_t      push
);

    logic     valid_reg;
    ntc_job_t job_reg;
    ntc_job_t job_next;
    logic     accept;
    logic [31:0] slot_w;

    assign busy = valid_reg && queue_full;
    assign accept = start && !busy;

    always_comb
    begin
        slot_w = 32'(sample.module_index) * 32'(THERMS_PER_MODULE) + 32'(sample.sensor_index);
        job_next.tag.slot = slot_w[6:0];
        job_next.tag.fault = (sample.adc_code == 16'd0) || (sample.adc_code >= FULL_SCALE);
        job_next.code = sample.adc_code[14:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (!queue_full)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg <= job_next;
        end
    end

    assign push.valid = valid_reg && !queue_full;
    assign push.job = job_reg;

endmodule
`default_nettype wire

// ===== src/ntc_queue.sv =====
// Short item queue between the front end and the conversion pipeline.
`default_nettype none
module ntc_queue
    import ntc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire ntc_push_t push,
    output logic           full,
    output logic           pop,
    output ntc_job_t       head
);

    localparam int PW = $clog2(QDEPTH);

    ntc_job_t        mem_reg [QDEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW:0]     count_reg;

    assign full = (count_reg == (PW+1)'(QDEPTH));
    assign pop = (count_reg != '0);
    assign head = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push.valid)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (PW+1)'(push.valid) - (PW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem_reg[wr_ptr_reg] <= push.job;
        end
    end

endmodule
`default_nettype wire

// ===== src/ntc_log2.sv =====
// Pipelined base-2 logarithm in unsigned Q4.32, one mantissa squaring per stage.
`default_nettype none
module ntc_log2
    import ntc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic [14:0] x,
    output logic [35:0]      log_q32
);

    logic [3:0]  msb;
    logic [30:0] y0;
    logic [30:0] y_reg    [LOG_LAT];
    logic [31:0] frac_reg [LOG_LAT];
    logic [3:0]  msb_reg  [LOG_LAT];

    always_comb
    begin
        msb = '0;
        for (int i = 0; i < 15; i++)
        begin
            if (x[i])
            begin
                msb = 4'(i);
            end
        end
        y0 = 31'(x) << (5'd30 - 5'(msb));
    end

    always_ff @(posedge clk)
    begin
        y_reg[0] <= y0;
        frac_reg[0] <= '0;
        msb_reg[0] <= msb;
    end

    for (genvar k = 0; k < LOG_LAT - 1; k++)
    begin : g_round
        logic [61:0] prod;
        logic [31:0] sq;
        assign prod = 62'(y_reg[k]) * 62'(y_reg[k]);
        assign sq = prod[61:30];
        always_ff @(posedge clk)
        begin
            y_reg[k+1] <= sq[31] ? sq[31:1] : sq[30:0];
            frac_reg[k+1] <= frac_reg[k] | ({31'b0, sq[31]} << (31 - k));
            msb_reg[k+1] <= msb_reg[k];
        end
    end

    assign log_q32 = {msb_reg[LOG_LAT-1], frac_reg[LOG_LAT-1]};

endmodule
`default_nettype wire

// ===== src/ntc_back.sv =====
// Conversion pipeline: log ratio, beta term, reciprocal and scaling to degrees.
`default_nettype none
module ntc_back
    import ntc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     pop,
    input  wire ntc_job_t head,
    output logic          done,
    output ntc_out_t      result
);

    logic [14:0] x_code;
    logic [14:0] x_rest;
    logic [35:0] lc;
    logic [35:0] lr;
    logic [15:0] rest_w;

    assign rest_w = FULL_SCALE - {1'b0, head.code};
    assign x_code = head.tag.fault ? 15'd1 : head.code;
    assign x_rest = head.tag.fault ? 15'd1 : rest_w[14:0];

    ntc_log2 u_log_code (.clk(clk), .x(x_code), .log_q32(lc));
    ntc_log2 u_log_rest (.clk(clk), .x(x_rest), .log_q32(lr));

    logic     l_v_reg   [LOG_LAT];
    ntc_tag_t l_tag_reg [LOG_LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LOG_LAT; i++)
            begin
                l_v_reg[i] <= 1'b0;
            end
        end
        else
        begin
            l_v_reg[0] <= pop;
            for (int i = 1; i < LOG_LAT; i++)
            begin
                l_v_reg[i] <= l_v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        l_tag_reg[0] <= head.tag;
        for (int i = 1; i < LOG_LAT; i++)
        begin
            l_tag_reg[i] <= l_tag_reg[i-1];
        end
    end

    logic        d_v_reg;
    ntc_tag_t    d_tag_reg;
    logic        d_neg_reg;
    logic [35:0] d_mag_reg;

    logic        m_v_reg;
    ntc_tag_t    m_tag_reg;
    logic        m_neg_reg;
    logic [17:0] m_hi_reg;
    logic [45:0] m_lo_reg;

    logic [45:0] hi_prod;
    logic [64:0] ln_sum;

    assign hi_prod = 46'(m_hi_reg) * 46'(LN2_Q28);
    assign ln_sum = (65'(hi_prod) << 18) + 65'(m_lo_reg);

    // The beta division runs as long division in 16-bit digits, each digit found by
    // a reciprocal multiplication that is exact for dividends below 2^28.
    function automatic logic [15:0] beta_quot(input logic [27:0] num);
        logic [56:0] prod;
        prod = 57'(num) * 57'(RECIP_BETA);
        return prod[55:40];
    endfunction

    function automatic logic [11:0] beta_rem(input logic [27:0] num, input logic [15:0] quot);
        logic [27:0] diff;
        diff = num - 28'(quot) * 28'(BETA);
        return diff[11:0];
    endfunction

    logic        c_v_reg   [TDIV_STEPS+1];
    ntc_tag_t    c_tag_reg [TDIV_STEPS+1];
    logic        c_neg_reg [TDIV_STEPS+1];
    logic [36:0] c_ln_reg;
    logic [27:0] c_num1_reg;
    logic [15:0] c_low1_reg;
    logic [15:0] c_acc1_reg;
    logic [27:0] c_num2_reg;
    logic [15:0] c_acc2_reg;
    logic [27:0] c_num3_reg;
    logic [31:0] c_acc3_reg;
    logic [27:0] c_num4_reg;
    logic [31:0] c_acc4_reg;
    logic [52:0] c_term_reg;
    logic [27:0] num1;

    assign num1 = {7'b0, c_ln_reg[36:16]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_v_reg <= 1'b0;
            m_v_reg <= 1'b0;
            for (int i = 0; i <= TDIV_STEPS; i++)
            begin
                c_v_reg[i] <= 1'b0;
            end
        end
        else
        begin
            d_v_reg <= l_v_reg[LOG_LAT-1];
            m_v_reg <= d_v_reg;
            c_v_reg[0] <= m_v_reg;
            for (int i = 1; i <= TDIV_STEPS; i++)
            begin
                c_v_reg[i] <= c_v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        d_tag_reg <= l_tag_reg[LOG_LAT-1];
        d_neg_reg <= lc < lr;
        d_mag_reg <= (lc < lr) ? (lr - lc) : (lc - lr);
        m_tag_reg <= d_tag_reg;
        m_neg_reg <= d_neg_reg;
        m_hi_reg <= d_mag_reg[35:18];
        m_lo_reg <= 46'(d_mag_reg[17:0]) * 46'(LN2_Q28);
        c_tag_reg[0] <= m_tag_reg;
        c_neg_reg[0] <= m_neg_reg;
        c_ln_reg <= ln_sum[64:28];
        for (int i = 1; i <= TDIV_STEPS; i++)
        begin
            c_tag_reg[i] <= c_tag_reg[i-1];
            c_neg_reg[i] <= c_neg_reg[i-1];
        end
        c_num1_reg <= num1;
        c_low1_reg <= c_ln_reg[15:0];
        c_acc1_reg <= beta_quot(num1);
        c_num2_reg <= {beta_rem(c_num1_reg, c_acc1_reg), c_low1_reg};
        c_acc2_reg <= c_acc1_reg;
        c_num3_reg <= c_num2_reg;
        c_acc3_reg <= {c_acc2_reg, beta_quot(c_num2_reg)};
        c_num4_reg <= {beta_rem(c_num3_reg, c_acc3_reg[15:0]), 16'b0};
        c_acc4_reg <= c_acc3_reg;
        c_term_reg <= {5'b0, c_acc4_reg, beta_quot(c_num4_reg)};
    end

    logic [52:0] term;
    logic        over;
    ntc_tag_t    i_tag;

    assign term = c_term_reg;
    assign over = c_neg_reg[TDIV_STEPS] && (term >= 53'(T0_INV_Q48));

    always_comb
    begin
        i_tag = c_tag_reg[TDIV_STEPS];
        i_tag.fault = c_tag_reg[TDIV_STEPS].fault || over;
    end

    logic        e_v_reg   [QDIV_STEPS+1];
    ntc_tag_t    e_tag_reg [QDIV_STEPS+1];
    logic [41:0] e_inv_reg [QDIV_STEPS+1];
    logic [41:0] e_rem_reg [QDIV_STEPS+1];
    logic [25:0] e_q_reg   [QDIV_STEPS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_v_reg[0] <= 1'b0;
        end
        else
        begin
            e_v_reg[0] <= c_v_reg[TDIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        e_tag_reg[0] <= i_tag;
        e_inv_reg[0] <= c_neg_reg[TDIV_STEPS] ? (T0_INV_Q48 - term[41:0])
                                              : (T0_INV_Q48 + term[41:0]);
        e_rem_reg[0] <= QDIV_INIT;
        e_q_reg[0] <= '0;
    end

    for (genvar k = 0; k < QDIV_STEPS; k++)
    begin : g_qdiv
        logic [42:0] r2;
        logic        ge;
        logic [42:0] diff;
        assign r2 = {e_rem_reg[k], 1'b0};
        assign ge = r2 >= {1'b0, e_inv_reg[k]};
        assign diff = r2 - {1'b0, e_inv_reg[k]};
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                e_v_reg[k+1] <= 1'b0;
            end
            else
            begin
                e_v_reg[k+1] <= e_v_reg[k];
            end
        end
        always_ff @(posedge clk)
        begin
            e_tag_reg[k+1] <= e_tag_reg[k];
            e_inv_reg[k+1] <= e_inv_reg[k];
            e_rem_reg[k+1] <= ge ? diff[41:0] : r2[41:0];
            e_q_reg[k+1] <= {e_q_reg[k][24:0], ge};
        end
    end

    logic signed [26:0] v;
    logic [26:0]        a;
    logic [31:0]        p5;
    logic [12:0]        mag;
    logic signed [12:0] temp;
    logic               bad;

    always_comb
    begin
        v = $signed({1'b0, e_q_reg[QDIV_STEPS]}) - KELVIN_OFS_Q8;
        a = v[26] ? 27'(-v) : 27'(v);
        p5 = 32'(a[25:10]) * 32'(RECIP5);
        mag = p5[30:18];
        temp = v[26] ? -$signed(mag) : $signed(mag);
        bad = e_tag_reg[QDIV_STEPS].fault || (v < MIN_TEMP_SCALED);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done <= 1'b0;
        end
        else
        begin
            done <= e_v_reg[QDIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        result.temperature <= bad ? FAULT_TEMP : temp;
        result.slot_index <= e_tag_reg[QDIV_STEPS].slot;
    end

endmodule
`default_nettype wire

// ===== src/ntc_code_to_temperature_unit.sv =====
// Top level of the NTC code-to-temperature unit.
// Throughput: one item per cycle; the two 32-round log pipelines, the beta
// reciprocal stages and the bit-per-stage quotient divider are fully pipelined,
// so busy stays low in use.
// Reset clears all valid flags and the queue; no result follows reset.
`default_nettype none
module ntc_code_to_temperature_unit
    import ntc_pkg::*;
#(
    parameter int THERMS_PER_MODULE = 16
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire ntc_in_t sample,
    output logic         done,
    output ntc_out_t     result
);

    ntc_push_t push;
    logic      queue_full;
    logic      pop;
    ntc_job_t  head;

    ntc_front #(.THERMS_PER_MODULE(THERMS_PER_MODULE)) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .sample(sample),
        .queue_full(queue_full),
        .busy(busy),
        .push(push)
    );

    ntc_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(queue_full),
        .pop(pop),
        .head(head)
    );

    ntc_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .pop(pop),
        .head(head),
        .done(done),
        .result(result)
    );

endmodule
`default_nettype wire
